FILE: src/assert_macros.svh
// Assertion macros used by the frame allocator sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: src/bfa_pkg.sv
// Types, constants and sizes shared by the frame allocator modules.
`timescale 1ns / 1ps
package bfa_pkg;
	localparam int unsigned NUM_FRAMES  = 131072;
	localparam int unsigned FRAME_SHIFT = 12;
	localparam int unsigned WORD_BITS   = 32;

	localparam int unsigned NWORDS  = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned WA_W    = $clog2(NWORDS);
	localparam int unsigned WC_W    = WA_W + 1;
	localparam int unsigned BIT_W   = $clog2(WORD_BITS);
	localparam int unsigned FN_W    = $clog2(NUM_FRAMES + 1);
	localparam int unsigned FREE_W  = $clog2(NWORDS * WORD_BITS + 1);
	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned CNT_W   = 18;
	localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned REGI_W  = PADDR_W - 2;

	localparam logic [REGI_W-1:0] REG_MANAGED = 1'd0;
	localparam logic [REGI_W-1:0] REG_ENABLE  = 1'd1;

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_FREE    = 2'd1,
		REQ_RESERVE = 2'd2,
		REQ_RELEASE = 2'd3
	} bfa_req_type_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_NOFREE  = 2'd1,
		STS_IGNORED = 2'd2
	} bfa_status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_RANGE,
		S_DONE
	} bfa_state_t;

	typedef struct packed {
		bfa_req_type_t      req_type;
		logic [ADDR_W-1:0]  addr;
		logic [ADDR_W-1:0]  end_addr;
	} bfa_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  frame_addr;
		bfa_status_t        status;
		logic [CNT_W-1:0]   free_count;
		logic [CNT_W-1:0]   used_count;
	} bfa_rsp_t;

	typedef struct packed {
		logic              enable;
		logic [FN_W-1:0]   total;
	} bfa_cfg_t;

	typedef struct packed {
		logic                  rd_en;
		logic [WA_W-1:0]       rd_addr;
		logic                  wr_en;
		logic [WA_W-1:0]       wr_addr;
		logic [WORD_BITS-1:0]  wr_data;
	} bfa_mem_req_t;
endpackage

FILE: src/bfa_ram.sv
// Simple dual-port bitmap RAM: one write port, one registered read port.
`timescale 1ns / 1ps
module bfa_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

FILE: src/bfa_cfg.sv
// APB register file: managed frame count and enable, with clamped total.
`timescale 1ns / 1ps
module bfa_cfg import bfa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output bfa_cfg_t           cfg
);
	logic [CNT_W-1:0]  managed_q;
	logic              enable_q;
	logic [REGI_W-1:0] reg_idx;
	logic              wr_stb;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_stb  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			managed_q <= '0;
			enable_q  <= 1'b0;
		end else if (wr_stb) begin
			case (reg_idx)
				REG_MANAGED: managed_q <= pwdata[CNT_W-1:0];
				REG_ENABLE:  enable_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MANAGED: prdata = PDATA_W'(managed_q);
			REG_ENABLE:  prdata = PDATA_W'(enable_q);
			default:     prdata = '0;
		endcase
	end

	// Frames beyond the bitmap are never managed.
	assign cfg.enable = enable_q;
	assign cfg.total  = (managed_q > CNT_W'(NUM_FRAMES)) ? FN_W'(NUM_FRAMES) : FN_W'(managed_q);
endmodule

FILE: src/bfa_ctrl.sv
// Request sequencer: decodes requests, scans and modifies bitmap words.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bfa_ctrl import bfa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bfa_cfg_t             cfg,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  bfa_req_t             req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output bfa_rsp_t             rsp,
	output bfa_mem_req_t         mem,
	input  logic [WORD_BITS-1:0] rd_data
);
	localparam int unsigned FR_W  = ADDR_W - FRAME_SHIFT;
	localparam int unsigned LIM_W = FN_W + FRAME_SHIFT;

	function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

	function automatic logic [BIT_W:0] popcount(input logic [WORD_BITS-1:0] w);
		logic [BIT_W:0] n;
		n = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			n = n + (BIT_W+1)'(w[i]);
		end
		return n;
	endfunction

	function automatic logic [CNT_W-1:0] sat_cnt(input logic [FREE_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (32'(v) > CNT_MAX) begin
			r = CNT_W'(CNT_MAX);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

	bfa_state_t           state_q, state_d;
	bfa_req_t             req_q;
	logic [WC_W-1:0]      word_q;
	logic [WA_W-1:0]      ws_q, we_q;
	logic [BIT_W-1:0]     lo_q, hi_q;
	logic                 set_q;
	logic                 pend_s1;
	logic [WA_W-1:0]      pend_word_s1;
	logic [FREE_W-1:0]    free_q;
	logic [WC_W-1:0]      hint_q;
	logic [ADDR_W-1:0]    fa_q;
	bfa_status_t          sts_q;
	logic                 rsp_valid_q;
	bfa_rsp_t             rsp_q;

	// Decode of the latched request.
	logic [FR_W-1:0]      fr_d;
	logic [FR_W-1:0]      last_fr_d;
	logic                 aligned_d;
	logic [LIM_W-1:0]     limit_d;
	logic [ADDR_W-1:0]    endc_d;
	logic [ADDR_W-1:0]    last_byte_d;
	logic                 range_bad_d;
	logic                 free_bad_d;
	logic                 hint_full_d;
	logic [WA_W-1:0]      start_word_d;

	// Scan and modify datapath.
	logic                 can_issue_scan, can_issue_range, issue;
	logic                 word_full;
	logic [BIT_W-1:0]     zbit;
	logic [WA_W+BIT_W-1:0] found_f;
	logic                 found_ok;
	logic                 scan_exhausted, scan_end, range_end;
	logic [BIT_W-1:0]     lo_eff, hi_eff;
	logic [WORD_BITS-1:0] mask, changed, new_word;
	logic [BIT_W:0]       pop;
	logic [FREE_W-1:0]    total_w, used_w;
	logic                 load_rsp;

	assign fr_d        = req_q.addr[ADDR_W-1:FRAME_SHIFT];
	assign aligned_d   = (req_q.addr[FRAME_SHIFT-1:0] == '0);
	assign limit_d     = {cfg.total, {FRAME_SHIFT{1'b0}}};
	assign range_bad_d = (req_q.addr >= req_q.end_addr) || (req_q.addr >= limit_d);
	assign endc_d      = (req_q.end_addr > limit_d) ? ADDR_W'(limit_d) : req_q.end_addr;
	// The last frame touched is the one holding the last byte before the end.
	assign last_byte_d = endc_d - ADDR_W'(1);
	assign last_fr_d   = last_byte_d[ADDR_W-1:FRAME_SHIFT];
	assign free_bad_d  = !aligned_d || (fr_d >= cfg.total);
	assign hint_full_d = ({hint_q, {BIT_W{1'b0}}} >= cfg.total);
	assign start_word_d = fr_d[BIT_W +: WA_W];

	assign can_issue_scan  = (word_q < WC_W'(NWORDS)) &&
	                         ({word_q, {BIT_W{1'b0}}} < cfg.total);
	assign can_issue_range = (word_q <= {1'b0, we_q});
	assign issue = ((state_q == S_SCAN) && can_issue_scan) ||
	               ((state_q == S_RANGE) && can_issue_range);

	assign word_full = &rd_data;
	assign zbit      = lowest_zero(rd_data);
	assign found_f   = {pend_word_s1, zbit};
	assign found_ok  = (found_f < cfg.total);
	assign scan_exhausted = !pend_s1 && !can_issue_scan;
	assign scan_end  = (pend_s1 && !word_full) || scan_exhausted;
	assign range_end = pend_s1 && (pend_word_s1 == we_q);

	assign lo_eff   = (pend_word_s1 == ws_q) ? lo_q : '0;
	assign hi_eff   = (pend_word_s1 == we_q) ? hi_q : BIT_W'(WORD_BITS - 1);
	assign mask     = ({WORD_BITS{1'b1}} << lo_eff) &
	                  ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_eff));
	assign changed  = set_q ? (mask & ~rd_data) : (mask & rd_data);
	assign new_word = set_q ? (rd_data | mask) : (rd_data & ~mask);
	assign pop      = popcount(changed);

	assign total_w  = FREE_W'(cfg.total);
	assign used_w   = (total_w > free_q) ? (total_w - free_q) : '0;
	assign load_rsp = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (word_q == WC_W'(NWORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (req_q.req_type)
					REQ_ALLOC: state_d = (!cfg.enable || hint_full_d) ? S_DONE : S_SCAN;
					REQ_FREE:  state_d = (!cfg.enable || free_bad_d) ? S_DONE : S_RANGE;
					default:   state_d = range_bad_d ? S_DONE : S_RANGE;
				endcase
			end
			S_SCAN: begin
				if (scan_end) begin
					state_d = S_DONE;
				end
			end
			S_RANGE: begin
				if (range_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (load_rsp) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		mem.rd_en   = 1'b0;
		mem.rd_addr = word_q[WA_W-1:0];
		mem.wr_en   = 1'b0;
		mem.wr_addr = pend_word_s1;
		mem.wr_data = new_word;
		case (state_q)
			S_CLEAR: begin
				mem.wr_en   = 1'b1;
				mem.wr_addr = word_q[WA_W-1:0];
				mem.wr_data = '1;
			end
			S_IDLE: begin
				req_ready = 1'b1;
			end
			S_SCAN: begin
				mem.rd_en   = issue;
				mem.wr_en   = pend_s1 && !word_full && found_ok;
				mem.wr_data = rd_data | (WORD_BITS'(1) << zbit);
			end
			S_RANGE: begin
				mem.rd_en = issue;
				mem.wr_en = pend_s1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			word_q      <= '0;
			pend_s1     <= 1'b0;
			free_q      <= '0;
			hint_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					word_q <= word_q + WC_W'(1);
				end
				S_DECODE: begin
					if (req_q.req_type == REQ_ALLOC) begin
						word_q <= hint_q;
					end else begin
						word_q <= {1'b0, start_word_d};
					end
					// Releasing frames may open words below the scan hint.
					if (state_d == S_RANGE && req_q.req_type != REQ_RESERVE &&
					    {1'b0, start_word_d} < hint_q) begin
						hint_q <= {1'b0, start_word_d};
					end
				end
				S_SCAN: begin
					if (issue) begin
						word_q <= word_q + WC_W'(1);
					end
					if (pend_s1 && !word_full) begin
						hint_q <= {1'b0, pend_word_s1};
						if (found_ok && free_q != '0) begin
							free_q <= free_q - FREE_W'(1);
						end
					end else if (scan_exhausted) begin
						hint_q <= word_q;
					end
				end
				S_RANGE: begin
					if (issue) begin
						word_q <= word_q + WC_W'(1);
					end
					if (pend_s1) begin
						if (set_q) begin
							free_q <= (free_q > FREE_W'(pop)) ? free_q - FREE_W'(pop) : '0;
						end else begin
							free_q <= free_q + FREE_W'(pop);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		pend_word_s1 <= word_q[WA_W-1:0];
		case (state_q)
			S_DECODE: begin
				fa_q  <= '0;
				set_q <= (req_q.req_type == REQ_RESERVE);
				ws_q  <= start_word_d;
				lo_q  <= fr_d[BIT_W-1:0];
				if (req_q.req_type == REQ_FREE) begin
					we_q <= start_word_d;
					hi_q <= fr_d[BIT_W-1:0];
				end else begin
					we_q <= last_fr_d[BIT_W +: WA_W];
					hi_q <= last_fr_d[BIT_W-1:0];
				end
				case (req_q.req_type)
					REQ_ALLOC: sts_q <= STS_NOFREE;
					REQ_FREE:  sts_q <= !cfg.enable ? STS_NOFREE :
					                    (free_bad_d ? STS_IGNORED : STS_OK);
					default:   sts_q <= range_bad_d ? STS_IGNORED : STS_OK;
				endcase
			end
			S_SCAN: begin
				if (pend_s1 && !word_full && found_ok) begin
					fa_q  <= ADDR_W'({found_f, {FRAME_SHIFT{1'b0}}});
					sts_q <= STS_OK;
				end
			end
			default: ;
		endcase
		if (load_rsp) begin
			rsp_q <= '{frame_addr: fa_q, status: sts_q,
			           free_count: sat_cnt(free_q), used_count: sat_cnt(used_w)};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_NEVER(a_no_rw_same_word, clk, arst_n, mem.rd_en && mem.wr_en && (mem.rd_addr == mem.wr_addr), "bitmap word read and written in the same cycle")
	`ASSERT_CLK(a_rsp_after_done, clk, arst_n, $rose(rsp_valid_q) |-> $past(state_q == S_DONE), "response raised outside the done state")
	`ASSERT_CLK(a_range_in_bounds, clk, arst_n, (state_q == S_RANGE && pend_s1) |-> (pend_word_s1 >= ws_q && pend_word_s1 <= we_q), "range modify outside its word span")
endmodule

FILE: src/bitmap_frame_allocator.sv
// Top level of the first-fit bitmap frame allocator.
`timescale 1ns / 1ps
// Request flow: idle accepts the request, decode checks it, then an alloc scans words from the
// scan hint and a free, reserve or release walks its words in the range state, and done loads
// the response; a request settled at decode (disabled, ignored or nothing to scan) goes to done.
// Throughput: one request at a time over one 32-bit word per cycle; the next request is taken
// the cycle after a response is loaded, and a waiting response holds it in its done state.
// Reset: asynchronous; a clearing pass then marks all 4096 words used, req_ready low.
module bitmap_frame_allocator import bfa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration port: managed frame count at 0x0, enable at 0x4.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// Request channel: one beat per alloc, free, reserve or release request.
	input  logic               req_valid,
	output logic               req_ready,
	input  bfa_req_t           req,
	// Response channel: one beat per request, in order.
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output bfa_rsp_t           rsp
);
	bfa_cfg_t             cfg;
	bfa_mem_req_t         mem;
	logic [WORD_BITS-1:0] rd_data;

	// Configuration registers. The effective frame count is clamped to the bitmap size.
	bfa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The sequencer owns every bitmap access. Reads are issued one word per cycle and
	// the data returns in the next cycle, when the word is modified and written back. The
	// next read always targets a different word, so no forwarding path is needed.
	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.mem       (mem),
		.rd_data   (rd_data)
	);

	// Used/free bitmap, one bit per frame, a set bit meaning used.
	bfa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NWORDS),
		.AW    (WA_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem.wr_en),
		.wr_addr (mem.wr_addr),
		.wr_data (mem.wr_data),
		.rd_en   (mem.rd_en),
		.rd_addr (mem.rd_addr),
		.rd_data (rd_data)
	);
endmodule

FILE: tb/bitmap_frame_allocator_tb.sv
// Self-checking testbench for the first-fit bitmap frame allocator.
`timescale 1ns / 1ps
module bitmap_frame_allocator_tb;
	import bfa_pkg::*;

	// Run shape. The watchdog limit covers the clearing pass after reset, a range beat
	// that walks every bitmap word, and the long response hold-off, several times over.
	localparam int unsigned ITEM_TARGET      = 1950;
	localparam int unsigned LONG_HOLD_CYCLES = 400;
	localparam int unsigned WATCHDOG_LIMIT   = 20000;
	localparam int unsigned SETTLE_CYCLES    = 8;
	localparam int unsigned END_CYCLES       = 16;
	localparam logic [ADDR_W-1:0] ALL_ONES   = '1;

	// Keeps a private copy of the bitmap, the free count and both registers. Every
	// accepted request beat is turned into the response it must produce, and the
	// responses are matched in order against that list.
	class frame_tracker;
		bit [WORD_BITS-1:0] used_map [NWORDS];
		int unsigned        free_total;
		bit [CNT_W-1:0]     managed;
		bit                 enabled;
		bfa_rsp_t           pending_rsp [$];
		int unsigned        errors;

		function void clear_state();
			foreach (used_map[w])
				used_map[w] = '1;
			free_total = 0;
			managed = '0;
			enabled = 1'b0;
			errors = 0;
			pending_rsp.delete();
		endfunction

		function void write_reg(logic [REGI_W-1:0] idx, logic [PDATA_W-1:0] value);
			case (idx)
			REG_MANAGED: begin
				managed = value[CNT_W-1:0];
			end
			REG_ENABLE: begin
				enabled = value[0];
			end
			default: ;
			endcase
		endfunction

		function bit frame_used(int unsigned fr);
			return used_map[fr / WORD_BITS][fr % WORD_BITS];
		endfunction

		function void mark_frame(int unsigned fr, bit used);
			used_map[fr / WORD_BITS][fr % WORD_BITS] = used;
		endfunction

		function void note_request(bfa_req_t item);
			bfa_rsp_t          want;
			int unsigned       total;
			int unsigned       fr;
			int unsigned       stop;
			int unsigned       used;
			longint unsigned   limit;
			longint unsigned   first;
			longint unsigned   last;
			bit                found;
			total = (managed > NUM_FRAMES) ? NUM_FRAMES : managed;
			limit = 64'(total) << FRAME_SHIFT;
			want = '0;
			want.status = STS_OK;
			case (item.req_type)
			REQ_ALLOC: begin
				if (!enabled) begin
					want.status = STS_NOFREE;
				end else begin
					// First fit: skip whole words that are fully used.
					fr = 0;
					found = 1'b0;
					while (!found && fr < total) begin
						if (fr % WORD_BITS == 0 && &used_map[fr / WORD_BITS])
							fr += WORD_BITS;
						else if (!frame_used(fr))
							found = 1'b1;
						else
							fr++;
					end
					if (found) begin
						mark_frame(fr, 1'b1);
						if (free_total > 0)
							free_total--;
						want.frame_addr = 32'(fr) << FRAME_SHIFT;
					end else begin
						want.status = STS_NOFREE;
					end
				end
			end
			REQ_FREE: begin
				if (!enabled) begin
					want.status = STS_NOFREE;
				end else if (item.addr[FRAME_SHIFT-1:0] != '0 ||
						(item.addr >> FRAME_SHIFT) >= total) begin
					want.status = STS_IGNORED;
				end else begin
					fr = item.addr >> FRAME_SHIFT;
					if (frame_used(fr)) begin
						mark_frame(fr, 1'b0);
						free_total++;
					end
				end
			end
			default: begin
				// Reserve and release run whether or not the allocator is enabled.
				first = 64'(item.addr);
				last = 64'(item.end_addr);
				if (first >= last || first >= limit) begin
					want.status = STS_IGNORED;
				end else begin
					if (last > limit)
						last = limit;
					stop = 32'((last + (64'd1 << FRAME_SHIFT) - 1) >> FRAME_SHIFT);
					for (fr = 32'(first >> FRAME_SHIFT); fr < stop; fr++) begin
						if (item.req_type == REQ_RESERVE && !frame_used(fr)) begin
							mark_frame(fr, 1'b1);
							if (free_total > 0)
								free_total--;
						end else if (item.req_type == REQ_RELEASE && frame_used(fr)) begin
							mark_frame(fr, 1'b0);
							free_total++;
						end
					end
				end
			end
			endcase
			// A shrunk count can leave more free frames than managed ones.
			used = (total > free_total) ? total - free_total : 0;
			want.free_count = CNT_W'((free_total > CNT_MAX) ? CNT_MAX : free_total);
			want.used_count = CNT_W'((used > CNT_MAX) ? CNT_MAX : used);
			pending_rsp.push_back(want);
		endfunction

		function void flag(string what, logic [ADDR_W-1:0] want_v, logic [ADDR_W-1:0] got_v);
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
		endfunction

		function void check_response(bfa_rsp_t got);
			bfa_rsp_t want;
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("%0t: response with none outstanding, expected none, got %h",
					$time, got);
				return;
			end
			want = pending_rsp.pop_front();
			if (got.frame_addr !== want.frame_addr)
				flag("frame_addr", want.frame_addr, got.frame_addr);
			if (got.status !== want.status)
				flag("status", 32'(want.status), 32'(got.status));
			if (got.free_count !== want.free_count)
				flag("free_count", 32'(want.free_count), 32'(got.free_count));
			if (got.used_count !== want.used_count)
				flag("used_count", 32'(want.used_count), 32'(got.used_count));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               req_valid;
	logic               req_ready;
	bfa_req_t           req;
	logic               rsp_valid;
	logic               rsp_ready;
	bfa_rsp_t           rsp;

	frame_tracker       tracker;
	int unsigned        hold_asks = 0;
	int unsigned        beats_sent = 0;
	int unsigned        idle_cycles = 0;

	bitmap_frame_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both channels are sampled at the rising edge, before any of this edge's updates
	// land, so a beat is seen exactly when valid and ready were both high.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				tracker.note_request(req);
			if (rsp_valid && rsp_ready)
				tracker.check_response(rsp);
		end
	end

	// Watchdog: any accepted beat on either channel restarts the count.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Response side. Ready follows segments of random length, each with its own
	// chance of being high, from always ready down to mostly stalled. Each time the
	// stimulus asks for it, ready is held low for a long stretch so the block backs
	// up and has to stall its request channel.
	initial begin : rsp_side
		int unsigned seg;
		int unsigned pick;
		int unsigned ready_pct;
		int unsigned stall;
		int unsigned holds_done;
		holds_done = 0;
		rsp_ready <= 1'b0;
		forever begin
			if (hold_asks > holds_done) begin
				stall = 0;
				while (stall < LONG_HOLD_CYCLES) begin
					@(posedge clk);
					rsp_ready <= 1'b0;
					stall++;
				end
				holds_done++;
			end else begin
				pick = $urandom_range(0, 3);
				ready_pct = (pick == 0) ? 100 : pick * 30;
				seg = $urandom_range(1, 60);
				repeat (seg) begin
					@(posedge clk);
					rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
				end
			end
		end
	end

	function automatic bfa_req_t make_req(bfa_req_type_t kind, logic [ADDR_W-1:0] start,
			logic [ADDR_W-1:0] stop_addr);
		bfa_req_t item;
		item.req_type = kind;
		item.addr = start;
		item.end_addr = stop_addr;
		return item;
	endfunction

	// Mostly well-formed requests: frees of aligned frames near or below the count,
	// short ranges inside the managed space with an occasional ragged edge. About
	// one in ten is raw noise over the full address space.
	function automatic bfa_req_t random_req(int unsigned total);
		bfa_req_t    item;
		int unsigned pick;
		int unsigned first;
		int unsigned span;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			item.req_type = REQ_ALLOC;
		else if (pick < 65)
			item.req_type = REQ_FREE;
		else if (pick < 82)
			item.req_type = REQ_RESERVE;
		else
			item.req_type = REQ_RELEASE;
		item.addr = $urandom();
		item.end_addr = $urandom();
		if ($urandom_range(0, 9) == 0)
			return item;
		case (item.req_type)
		REQ_FREE: begin
			first = $urandom_range(0, total + 1);
			item.addr = 32'(first) << FRAME_SHIFT;
			if ($urandom_range(0, 15) == 0)
				item.addr[FRAME_SHIFT-1:0] =
					FRAME_SHIFT'($urandom_range(1, (1 << FRAME_SHIFT) - 1));
		end
		REQ_RESERVE, REQ_RELEASE: begin
			first = $urandom_range(0, total + 2);
			span = $urandom_range(1, 48);
			item.addr = 32'(first) << FRAME_SHIFT;
			item.end_addr = item.addr + (32'(span) << FRAME_SHIFT);
			if ($urandom_range(0, 3) == 0) begin
				item.addr += $urandom_range(0, (1 << FRAME_SHIFT) - 1);
				item.end_addr -= $urandom_range(0, (1 << FRAME_SHIFT) - 1);
			end
		end
		default: ;
		endcase
		return item;
	endfunction

	// Two-phase APB write; the register takes the value at the access edge, and the port
	// then idles before the task returns.
	task automatic apb_write(input logic [REGI_W-1:0] idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.write_reg(idx, value);
		@(posedge clk);
	endtask

	// Offers the beats in bursts of random length with random gaps; now and then a
	// long burst keeps valid high back to back.
	task automatic send_batch(input bfa_req_t batch [$]);
		int unsigned idx;
		int unsigned burst;
		idx = 0;
		burst = $urandom_range(1, 24);
		while (idx < batch.size()) begin
			req <= batch[idx];
			req_valid <= 1'b1;
			do @(posedge clk); while (!req_ready);
			idx++;
			beats_sent++;
			burst--;
			if (burst == 0 || idx == batch.size()) begin
				req_valid <= 1'b0;
				if (idx < batch.size()) begin
					repeat ($urandom_range(1, 12)) @(posedge clk);
					burst = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
				end
			end
		end
	endtask

	// Every request has exactly one response, so an empty list means the block is idle.
	// The last beat is logged at the edge that accepts it, so look only after that edge.
	task automatic drain();
		@(posedge clk);
		while (tracker.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		bfa_req_t    batch [$];
		int unsigned managed_cfg;
		int unsigned total;
		int unsigned pick;
		int unsigned count;
		int unsigned phase;
		bit          enable_cfg;

		tracker = new;
		tracker.clear_state();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Out of reset nothing is managed and the allocator is off: alloc and free
		// report no free frame, and a range starts at or above an empty limit.
		batch = {};
		batch.push_back(make_req(REQ_ALLOC, '0, ALL_ONES));
		batch.push_back(make_req(REQ_FREE, '0, '0));
		batch.push_back(make_req(REQ_RESERVE, '0, 32'h1000));
		send_batch(batch);
		drain();

		// Ranges ignore the enable bit, so a release still works while disabled.
		apb_write(REG_MANAGED, 32'd100);
		batch = {};
		batch.push_back(make_req(REQ_RELEASE, '0, 32'd100 << FRAME_SHIFT));
		batch.push_back(make_req(REQ_ALLOC, '0, '0));
		batch.push_back(make_req(REQ_FREE, 32'h2000, '0));
		send_batch(batch);
		drain();

		// Enabled with 100 frames: frame zero comes back as address 0 with a good
		// status, a repeated free is harmless, misaligned and out-of-range frees are
		// ignored, empty and inverted ranges are ignored, a ragged range rounds out
		// to whole frames, and a full reserve leaves alloc with nothing to give.
		apb_write(REG_ENABLE, 32'd1);
		batch = {};
		batch.push_back(make_req(REQ_ALLOC, '0, '0));
		batch.push_back(make_req(REQ_ALLOC, ALL_ONES, ALL_ONES));
		batch.push_back(make_req(REQ_FREE, 32'h1000, '0));
		batch.push_back(make_req(REQ_FREE, 32'h1000, ALL_ONES));
		batch.push_back(make_req(REQ_FREE, 32'h1001, '0));
		batch.push_back(make_req(REQ_FREE, 32'd100 << FRAME_SHIFT, '0));
		batch.push_back(make_req(REQ_FREE, 32'hFFFF_F000, '0));
		batch.push_back(make_req(REQ_RESERVE, 32'h5000, 32'h5000));
		batch.push_back(make_req(REQ_RELEASE, 32'h9000, 32'h3000));
		batch.push_back(make_req(REQ_RESERVE, 32'h1800, 32'h2801));
		batch.push_back(make_req(REQ_RELEASE, 32'd100 << FRAME_SHIFT, ALL_ONES));
		batch.push_back(make_req(REQ_RESERVE, '0, ALL_ONES));
		batch.push_back(make_req(REQ_ALLOC, '0, '0));
		batch.push_back(make_req(REQ_RELEASE, '0, ALL_ONES));
		send_batch(batch);
		drain();

		// All register bits set: the count clips to the full bitmap. Only the top
		// frame is left free, so alloc must walk the whole map to find it.
		apb_write(REG_MANAGED, CNT_MAX);
		batch = {};
		batch.push_back(make_req(REQ_RELEASE, 32'd131071 << FRAME_SHIFT, ALL_ONES));
		batch.push_back(make_req(REQ_RESERVE, '0, 32'd131071 << FRAME_SHIFT));
		batch.push_back(make_req(REQ_ALLOC, '0, '0));
		batch.push_back(make_req(REQ_FREE, 32'd131071 << FRAME_SHIFT, '0));
		batch.push_back(make_req(REQ_RELEASE, 32'h0010_0000, 32'h0014_0000));
		send_batch(batch);
		drain();

		// Shrinking the count below the free frames: those stay counted but are never
		// handed out, and the used count bottoms out at zero.
		apb_write(REG_MANAGED, 32'd32);
		batch = {};
		batch.push_back(make_req(REQ_ALLOC, '0, '0));
		send_batch(batch);
		drain();

		// Random phases, each with its own setting. Most use a small count so the
		// bitmap walks stay short; a few use the full map or a mid-size one.
		phase = 0;
		while (beats_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (phase == 0)
				managed_cfg = NUM_FRAMES;
			else if (pick < 5)
				managed_cfg = 0;
			else if (pick < 9)
				managed_cfg = CNT_MAX;
			else if (pick < 20)
				managed_cfg = $urandom_range(1000, 20000);
			else
				managed_cfg = $urandom_range(1, 320);
			enable_cfg = ($urandom_range(0, 9) != 0);
			total = (managed_cfg > NUM_FRAMES) ? NUM_FRAMES : managed_cfg;
			count = (managed_cfg > 2048) ? 30 : $urandom_range(60, 160);

			apb_write(REG_MANAGED, managed_cfg);
			apb_write(REG_ENABLE, 32'(enable_cfg));

			batch = {};
			// Often start from a clean slate with every managed frame free.
			if ($urandom_range(0, 1) == 1)
				batch.push_back(make_req(REQ_RELEASE, '0, 32'(total) << FRAME_SHIFT));
			repeat (count)
				batch.push_back(random_req(total));

			// Two phases run against a stalled response channel.
			if (phase == 1 || phase == 4)
				hold_asks++;
			send_batch(batch);
			drain();
			phase++;
		end

		repeat (END_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_rsp.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
